>>> design/trhm_pkg.sv
// trhm_pkg: shared types, codes and defaults for the traffic rate history monitor.
// No dependencies; used by every module of the block but trhm_peak_unit.
package trhm_pkg;

    // Default number of history slots per direction
    localparam int HISTORY_SLOTS_DEF = 32;

    // Command codes
    localparam logic [1:0] CMD_TX    = 2'd0;
    localparam logic [1:0] CMD_RX    = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // Idle sample count at which the link reads as quiet
    localparam logic [1:0] IDLE_LIMIT = 2'd3;

    // Register index (word select bit of paddr)
    localparam logic REG_SAMPLE_PERIOD = 1'b0;

    // Input item transfer
    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] byte_count;
        logic [4:0]  slot_index;
    } t_in_item;

    // Result item transfer
    typedef struct packed {
        logic [63:0] total_tx_bytes;
        logic [63:0] total_rx_bytes;
        logic [63:0] tx_packet_count;
        logic [63:0] rx_packet_count;
        logic        link_active;
        logic [31:0] window_peak;
        logic [31:0] slot_tx_bytes;
        logic [31:0] slot_rx_bytes;
    } t_out_item;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DRAIN,
        ST_QUERY,
        ST_DONE
    } t_seq_state;

    // Sequencer controls toward the datapath
    typedef struct packed {
        logic in_ready;
        logic exec;
        logic peak_clr;
        logic scan_rd;
        logic query_rd;
        logic out_load;
    } t_seq_ctl;

endpackage

>>> design/trhm_hist_mem.sv
// trhm_hist_mem: history window storage, one word per slot holding {tx, rx}.
// Per-entry valid bits make never-written entries read as zero. Uses trhm_pkg only by name.
module trhm_hist_mem #(
    parameter int DEPTH = trhm_pkg::HISTORY_SLOTS_DEF,
    parameter int AW    = $clog2(trhm_pkg::HISTORY_SLOTS_DEF)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [63:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [63:0]   o_rdata
);

    logic [63:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [63:0]      r_rdata;
    logic             r_rd_valid;

    // Data array, no reset
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_raddr];
            end
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : 64'd0;

endmodule

>>> design/trhm_peak_unit.sv
// trhm_peak_unit: compare unit that folds one history word per cycle, while i_acc is high,
// into the running window peak. Depends on nothing.
module trhm_peak_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_clr,
    input  logic        i_acc,
    input  logic [31:0] i_tx,
    input  logic [31:0] i_rx,
    output logic [31:0] o_peak
);

    logic [31:0] r_peak;
    logic [31:0] n_peak;
    logic [31:0] w_pair_max;

    // Max of the two samples and the running value
    always_comb begin
        w_pair_max = (i_tx > i_rx) ? i_tx : i_rx;
        n_peak     = (w_pair_max > r_peak) ? w_pair_max : r_peak;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= 32'd0;
        end else if (i_clr) begin
            r_peak <= 32'd0;
        end else if (i_acc) begin
            r_peak <= n_peak;
        end
    end

    assign o_peak = r_peak;

endmodule

>>> design/trhm_seq.sv
// trhm_seq: steps each item: execute, rescan and drain on a sample, query, done.
// Depends on trhm_pkg (state enum and control struct).
module trhm_seq #(
    parameter int HISTORY_SLOTS = trhm_pkg::HISTORY_SLOTS_DEF,
    parameter int PW            = $clog2(trhm_pkg::HISTORY_SLOTS_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_fire,
    input  logic               i_sample,
    input  logic               i_out_free,
    output trhm_pkg::t_seq_ctl o_ctl,
    output logic [PW-1:0]      o_scan_addr
);

    trhm_pkg::t_seq_state r_state;
    trhm_pkg::t_seq_state n_state;
    logic [PW-1:0]        r_scan_cnt;
    logic                 w_scan_last;

    assign w_scan_last = (r_scan_cnt == PW'(HISTORY_SLOTS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            trhm_pkg::ST_IDLE: begin
                if (i_in_fire) n_state = trhm_pkg::ST_EXEC;
            end
            trhm_pkg::ST_EXEC: begin
                n_state = i_sample ? trhm_pkg::ST_SCAN : trhm_pkg::ST_QUERY;
            end
            trhm_pkg::ST_SCAN: begin
                if (w_scan_last) n_state = trhm_pkg::ST_DRAIN;
            end
            trhm_pkg::ST_DRAIN: begin
                n_state = trhm_pkg::ST_QUERY;
            end
            trhm_pkg::ST_QUERY: begin
                n_state = trhm_pkg::ST_DONE;
            end
            trhm_pkg::ST_DONE: begin
                if (i_out_free) n_state = trhm_pkg::ST_IDLE;
            end
            default: begin
                n_state = trhm_pkg::ST_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb begin
        o_ctl = '0;
        case (r_state)
            trhm_pkg::ST_IDLE: begin
                o_ctl.in_ready = 1'b1;
            end
            trhm_pkg::ST_EXEC: begin
                o_ctl.exec     = 1'b1;
                o_ctl.peak_clr = i_sample;
            end
            trhm_pkg::ST_SCAN: begin
                o_ctl.scan_rd = 1'b1;
            end
            trhm_pkg::ST_QUERY: begin
                o_ctl.query_rd = 1'b1;
            end
            trhm_pkg::ST_DONE: begin
                o_ctl.out_load = i_out_free;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    // State and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= trhm_pkg::ST_IDLE;
            r_scan_cnt <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == trhm_pkg::ST_EXEC) begin
                r_scan_cnt <= '0;
            end else if (r_state == trhm_pkg::ST_SCAN && !w_scan_last) begin
                r_scan_cnt <= r_scan_cnt + 1'b1;
            end
        end
    end

    assign o_scan_addr = r_scan_cnt;

endmodule

>>> design/traffic_rate_history_monitor_unit.sv
// Traffic rate history monitor: byte/packet totals, sampled history window and peak.
// Each item passes the execute, query and done states before its result is registered; a
// sampling tick adds the peak rescan, one history word per cycle through the single memory
// read port, and a drain state. No new item is taken until the last result is loaded.
// Reset (synchronous, active low) clears totals, pending sums, countdown, peak, period and
// history valid bits at once; idle count resets to quiet. Uses trhm_pkg and the submodules.
module traffic_rate_history_monitor_unit #(
    parameter int HISTORY_SLOTS = trhm_pkg::HISTORY_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  trhm_pkg::t_in_item  i_in_data,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output trhm_pkg::t_out_item o_out_data,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int PW = $clog2(HISTORY_SLOTS);
    localparam int SW = ((PW > 5) ? PW : 5) + 1;

    trhm_pkg::t_seq_ctl w_ctl;
    logic [PW-1:0]      w_scan_addr;
    logic               w_in_fire;
    logic               w_out_free;
    logic               w_sample;

    // Configuration
    logic [23:0] r_period;

    // Captured item
    logic [1:0]  r_cmd;
    logic [15:0] r_len;
    logic [4:0]  r_slot;

    // Counters and sampling state
    logic [63:0]   r_tx_total, n_tx_total;
    logic [63:0]   r_rx_total, n_rx_total;
    logic [63:0]   r_tx_pkts, n_tx_pkts;
    logic [63:0]   r_rx_pkts, n_rx_pkts;
    logic [31:0]   r_pend_tx, n_pend_tx;
    logic [31:0]   r_pend_rx, n_pend_rx;
    logic [1:0]    r_idle, n_idle;
    logic [23:0]   r_ticks, n_ticks;
    logic [PW-1:0] r_head, n_head;
    logic          r_acc;

    // Memory and peak
    logic [63:0]   w_rdata;
    logic [PW-1:0] w_raddr;
    logic [PW-1:0] w_qaddr;
    logic [PW:0]   w_qsum;
    logic [SW-1:0] w_slot_ext;
    logic          w_slot_ok;
    logic [31:0]   w_peak;

    // Output register
    logic                r_out_valid;
    trhm_pkg::t_out_item r_out_data;

    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_sample   = (r_cmd == trhm_pkg::CMD_TICK) && (r_ticks == 24'd0);
    assign o_in_ready = w_ctl.in_ready;

    // Sequencer
    trhm_seq #(
        .HISTORY_SLOTS (HISTORY_SLOTS),
        .PW            (PW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (w_in_fire),
        .i_sample    (w_sample),
        .i_out_free  (w_out_free),
        .o_ctl       (w_ctl),
        .o_scan_addr (w_scan_addr)
    );

    // Configuration port: writes land on the access phase
    assign pready = 1'b1;
    assign prdata = (paddr[2] == trhm_pkg::REG_SAMPLE_PERIOD) ? {8'd0, r_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 24'd0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == trhm_pkg::REG_SAMPLE_PERIOD) begin
            r_period <= pwdata[23:0];
        end
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_cmd  <= i_in_data.cmd;
            r_len  <= i_in_data.byte_count;
            r_slot <= i_in_data.slot_index;
        end
    end

    // Item execution
    always_comb begin
        n_tx_total = r_tx_total;
        n_rx_total = r_rx_total;
        n_tx_pkts  = r_tx_pkts;
        n_rx_pkts  = r_rx_pkts;
        n_pend_tx  = r_pend_tx;
        n_pend_rx  = r_pend_rx;
        n_idle     = r_idle;
        n_ticks    = r_ticks;
        n_head     = r_head;
        case (r_cmd)
            trhm_pkg::CMD_TX: begin
                n_tx_total = r_tx_total + 64'(r_len);
                n_tx_pkts  = r_tx_pkts + 64'd1;
                n_pend_tx  = r_pend_tx + 32'(r_len);
                n_idle     = 2'd0;
            end
            trhm_pkg::CMD_RX: begin
                if (r_len != 16'd0) begin
                    n_rx_total = r_rx_total + 64'(r_len);
                    n_rx_pkts  = r_rx_pkts + 64'd1;
                    n_pend_rx  = r_pend_rx + 32'(r_len);
                    n_idle     = 2'd0;
                end
            end
            trhm_pkg::CMD_TICK: begin
                if (w_sample) begin
                    // new sample overwrites the oldest slot
                    n_head    = (r_head == PW'(HISTORY_SLOTS - 1)) ? '0 : r_head + 1'b1;
                    n_pend_tx = 32'd0;
                    n_pend_rx = 32'd0;
                    if (r_pend_tx == 32'd0 && r_pend_rx == 32'd0) begin
                        n_idle = (r_idle == trhm_pkg::IDLE_LIMIT) ? r_idle : r_idle + 2'd1;
                    end else begin
                        n_idle = 2'd0;
                    end
                    n_ticks = (r_period > 24'd1) ? r_period - 24'd1 : 24'd0;
                end else begin
                    n_ticks = r_ticks - 24'd1;
                end
            end
            default: begin
                // query only: no state change
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_total <= 64'd0;
            r_rx_total <= 64'd0;
            r_tx_pkts  <= 64'd0;
            r_rx_pkts  <= 64'd0;
            r_pend_tx  <= 32'd0;
            r_pend_rx  <= 32'd0;
            r_idle     <= trhm_pkg::IDLE_LIMIT;
            r_ticks    <= 24'd0;
            r_head     <= '0;
            r_acc      <= 1'b0;
        end else begin
            r_acc <= w_ctl.scan_rd;
            if (w_ctl.exec) begin
                r_tx_total <= n_tx_total;
                r_rx_total <= n_rx_total;
                r_tx_pkts  <= n_tx_pkts;
                r_rx_pkts  <= n_rx_pkts;
                r_pend_tx  <= n_pend_tx;
                r_pend_rx  <= n_pend_rx;
                r_idle     <= n_idle;
                r_ticks    <= n_ticks;
                r_head     <= n_head;
            end
        end
    end

    // Logical slot to physical entry: oldest slot sits at the head
    assign w_slot_ext = SW'(r_slot);
    assign w_slot_ok  = w_slot_ext < SW'(HISTORY_SLOTS);
    assign w_qsum     = {1'b0, r_head} + {1'b0, w_slot_ext[PW-1:0]};
    assign w_qaddr    = (w_qsum >= (PW+1)'(HISTORY_SLOTS))
                        ? PW'(w_qsum - (PW+1)'(HISTORY_SLOTS)) : w_qsum[PW-1:0];
    assign w_raddr    = w_ctl.scan_rd ? w_scan_addr : w_qaddr;

    // History window
    trhm_hist_mem #(
        .DEPTH (HISTORY_SLOTS),
        .AW    (PW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_ctl.exec && w_sample),
        .i_waddr (r_head),
        .i_wdata ({r_pend_tx, r_pend_rx}),
        .i_re    (w_ctl.scan_rd || w_ctl.query_rd),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Peak rescan, one word per cycle
    trhm_peak_unit u_peak (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (w_ctl.peak_clr),
        .i_acc   (r_acc),
        .i_tx    (w_rdata[63:32]),
        .i_rx    (w_rdata[31:0]),
        .o_peak  (w_peak)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_data.total_tx_bytes  <= r_tx_total;
            r_out_data.total_rx_bytes  <= r_rx_total;
            r_out_data.tx_packet_count <= r_tx_pkts;
            r_out_data.rx_packet_count <= r_rx_pkts;
            r_out_data.link_active     <= (r_idle < trhm_pkg::IDLE_LIMIT);
            r_out_data.window_peak     <= w_peak;
            r_out_data.slot_tx_bytes   <= w_slot_ok ? w_rdata[63:32] : 32'd0;
            r_out_data.slot_rx_bytes   <= w_slot_ok ? w_rdata[31:0] : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> dv/traffic_rate_history_monitor_checker.sv
// Checker for the traffic rate history monitor: keeps its own copy of the counters and
// history window, predicts every result and compares it field by field.
// Depends on trhm_pkg; instantiated beside the block by traffic_rate_history_monitor_unit_test.
module traffic_rate_history_monitor_checker #(
    parameter int HISTORY_SLOTS = trhm_pkg::HISTORY_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input channel
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  trhm_pkg::t_in_item  i_in_data,
    // result channel
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  trhm_pkg::t_out_item i_out_data,
    // configuration port
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic [2:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    input  logic                i_pready,
    // status toward the testbench top
    output int                  o_fail_count,
    output int                  o_outstanding
);

    // Mirrored block state
    logic [23:0] period;
    logic [63:0] sent_bytes, recv_bytes, sent_pkts, recv_pkts;
    logic [31:0] sent_win [HISTORY_SLOTS];
    logic [31:0] recv_win [HISTORY_SLOTS];
    logic [31:0] sent_accum, recv_accum;
    logic [1:0]  quiet_count;
    logic [23:0] countdown;
    logic [31:0] peak;

    trhm_pkg::t_out_item expected_results [$];

    task clear_traffic_state();
        period      = '0;
        sent_bytes  = '0;
        recv_bytes  = '0;
        sent_pkts   = '0;
        recv_pkts   = '0;
        sent_accum  = '0;
        recv_accum  = '0;
        quiet_count = trhm_pkg::IDLE_LIMIT;
        countdown   = '0;
        peak        = '0;
        for (int i = 0; i < HISTORY_SLOTS; i++) begin
            sent_win[i] = '0;
            recv_win[i] = '0;
        end
        expected_results.delete();
    endtask

    // Shift both windows toward slot 0, append the pending sums, then rescan the peak
    task take_history_sample();
        for (int i = 0; i < HISTORY_SLOTS - 1; i++) begin
            sent_win[i] = sent_win[i + 1];
            recv_win[i] = recv_win[i + 1];
        end
        sent_win[HISTORY_SLOTS - 1] = sent_accum;
        recv_win[HISTORY_SLOTS - 1] = recv_accum;
        if (sent_accum == '0 && recv_accum == '0) begin
            if (quiet_count < trhm_pkg::IDLE_LIMIT) quiet_count++;
        end else begin
            quiet_count = '0;
        end
        sent_accum = '0;
        recv_accum = '0;
        peak = '0;
        for (int i = 0; i < HISTORY_SLOTS; i++) begin
            if (sent_win[i] > peak) peak = sent_win[i];
            if (recv_win[i] > peak) peak = recv_win[i];
        end
    endtask

    // Apply one transfer to the mirrored state and build the result it causes
    task predict_traffic_result(input trhm_pkg::t_in_item item,
                                output trhm_pkg::t_out_item res);
        case (item.cmd)
            trhm_pkg::CMD_TX: begin
                sent_bytes  += 64'(item.byte_count);
                sent_pkts   += 64'd1;
                sent_accum  += 32'(item.byte_count);
                quiet_count = '0;
            end
            trhm_pkg::CMD_RX: begin
                // empty receive leaves everything untouched
                if (item.byte_count != '0) begin
                    recv_bytes  += 64'(item.byte_count);
                    recv_pkts   += 64'd1;
                    recv_accum  += 32'(item.byte_count);
                    quiet_count = '0;
                end
            end
            trhm_pkg::CMD_TICK: begin
                if (countdown == '0) begin
                    take_history_sample();
                    countdown = (period > 24'd1) ? period - 24'd1 : '0;
                end else begin
                    countdown--;
                end
            end
            default: begin
                // query only: no state change
            end
        endcase
        res.total_tx_bytes  = sent_bytes;
        res.total_rx_bytes  = recv_bytes;
        res.tx_packet_count = sent_pkts;
        res.rx_packet_count = recv_pkts;
        res.link_active     = (quiet_count < trhm_pkg::IDLE_LIMIT);
        res.window_peak     = peak;
        if (item.slot_index < HISTORY_SLOTS) begin
            res.slot_tx_bytes = sent_win[item.slot_index];
            res.slot_rx_bytes = recv_win[item.slot_index];
        end else begin
            res.slot_tx_bytes = '0;
            res.slot_rx_bytes = '0;
        end
    endtask

    task check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
        if (exp !== act) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    // Config writes, result compare, then prediction of the new input transfer
    always @(posedge i_clk) begin
        trhm_pkg::t_out_item exp_res;
        trhm_pkg::t_out_item new_res;
        if (!i_rst_n) begin
            clear_traffic_state();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == trhm_pkg::REG_SAMPLE_PERIOD) begin
                period = i_pwdata[23:0];
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    check_field("total_tx_bytes", exp_res.total_tx_bytes,
                                i_out_data.total_tx_bytes);
                    check_field("total_rx_bytes", exp_res.total_rx_bytes,
                                i_out_data.total_rx_bytes);
                    check_field("tx_packet_count", exp_res.tx_packet_count,
                                i_out_data.tx_packet_count);
                    check_field("rx_packet_count", exp_res.rx_packet_count,
                                i_out_data.rx_packet_count);
                    check_field("link_active", 64'(exp_res.link_active),
                                64'(i_out_data.link_active));
                    check_field("window_peak", 64'(exp_res.window_peak),
                                64'(i_out_data.window_peak));
                    check_field("slot_tx_bytes", 64'(exp_res.slot_tx_bytes),
                                64'(i_out_data.slot_tx_bytes));
                    check_field("slot_rx_bytes", 64'(exp_res.slot_rx_bytes),
                                64'(i_out_data.slot_rx_bytes));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_traffic_result(i_in_data, new_res);
                expected_results.push_back(new_res);
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

>>> dv/traffic_rate_history_monitor_unit_test.sv
// Testbench top for traffic_rate_history_monitor_unit: clock, reset, stimulus, verdict.
// Depends on trhm_pkg, the block, and traffic_rate_history_monitor_checker.
module traffic_rate_history_monitor_unit_test;

    localparam logic [2:0] ADDR_PERIOD   = {trhm_pkg::REG_SAMPLE_PERIOD, 2'b00};
    localparam logic [2:0] ADDR_UNMAPPED = {~trhm_pkg::REG_SAMPLE_PERIOD, 2'b00};
    localparam int FULL_SIZE_BURST    = 20;  // run of full-size sends between two samples
    localparam int LONG_HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT        = 2000;
    localparam int DRAIN_CYCLES       = 60;

    logic                clk;
    logic                rst_n;
    logic                in_valid, in_ready;
    trhm_pkg::t_in_item  in_data;
    logic                out_valid, out_ready;
    trhm_pkg::t_out_item out_data;
    logic                psel, penable, pwrite, pready;
    logic [2:0]          paddr;
    logic [31:0]         pwdata, prdata;
    int                  fail_count, outstanding;
    bit                  idle_en;
    bit                  long_hold_req;
    int                  stall_cycles;

    traffic_rate_history_monitor_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    traffic_rate_history_monitor_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic trhm_pkg::t_in_item traffic_item(logic [1:0] cmd, logic [15:0] len,
                                                        logic [4:0] slot);
        trhm_pkg::t_in_item item;
        item.cmd        = cmd;
        item.byte_count = len;
        item.slot_index = slot;
        return item;
    endfunction

    // Random mix: mostly traffic, a fair share of ticks, some queries
    function automatic trhm_pkg::t_in_item rand_traffic_item();
        trhm_pkg::t_in_item item;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 6)       item.cmd = trhm_pkg::CMD_TX;
        else if (pick < 12) item.cmd = trhm_pkg::CMD_RX;
        else if (pick < 17) item.cmd = trhm_pkg::CMD_TICK;
        else                item.cmd = trhm_pkg::CMD_QUERY;
        case ($urandom_range(0, 9))
            0:       item.byte_count = '0;
            1:       item.byte_count = 16'hFFFF;
            2, 3, 4: item.byte_count = 16'($urandom_range(1, 1500));
            default: item.byte_count = 16'($urandom);
        endcase
        item.slot_index = ($urandom_range(0, 3) == 0) ? 5'd31 : 5'($urandom_range(0, 31));
        return item;
    endfunction

    // Entered and left at a falling edge; valid stays high for back-to-back transfers
    task automatic push_item(input trhm_pkg::t_in_item item);
        int gap;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic run_random_phase(input int count);
        repeat (count) push_item(rand_traffic_item());
    endtask

    // Stop offering items until every expected result has come back
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side: random ready bursts, one long hold-off on request
    initial begin
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (long_hold_req) begin
                out_ready <= 1'b0;
                long_hold_req = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end else if (idle_en && $urandom_range(0, 2) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
            else stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        in_valid      = 1'b0;
        in_data       = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        rst_n         = 1'b0;
        idle_en       = 1'b1;
        long_hold_req = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, period at reset value: every tick samples
        push_item(traffic_item(trhm_pkg::CMD_QUERY, 16'hFFFF, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'hFFFF, 5'd31));  // sample while quiet
        push_item(traffic_item(trhm_pkg::CMD_TX, 16'h0000, 5'd31));  // zero-length send counts
        push_item(traffic_item(trhm_pkg::CMD_RX, 16'h0000, 5'd0));     // empty receive
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd31));  // nothing pending
        push_item(traffic_item(trhm_pkg::CMD_TX, 16'hFFFF, 5'd0));
        push_item(traffic_item(trhm_pkg::CMD_RX, 16'hFFFF, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_RX, 16'h0001, 5'd30));
        push_item(traffic_item(trhm_pkg::CMD_TX, 16'h0001, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_QUERY, 16'h0000, 5'd30));
        // idle count climbs and saturates
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h5A5A, 5'd30));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'hA5A5, 5'd29));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_QUERY, 16'h0000, 5'd27));
        push_item(traffic_item(trhm_pkg::CMD_QUERY, 16'h0000, 5'd0));
        push_item(traffic_item(trhm_pkg::CMD_RX, 16'h8000, 5'd15));
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd16));

        // a run of full-size sends between two samples
        idle_en = 1'b0;
        repeat (FULL_SIZE_BURST) begin
            push_item(traffic_item(trhm_pkg::CMD_TX, 16'hFFFF, 5'($urandom)));
        end
        push_item(traffic_item(trhm_pkg::CMD_TICK, 16'h0000, 5'd31));
        push_item(traffic_item(trhm_pkg::CMD_QUERY, 16'h0000, 5'd31));
        idle_en = 1'b1;

        wait_idle();
        write_reg(ADDR_PERIOD, 32'd1);
        write_reg(ADDR_UNMAPPED, 32'd5);  // no such register, must be ignored
        run_random_phase(100);

        wait_idle();
        write_reg(ADDR_PERIOD, 32'd3);
        long_hold_req = 1'b1;  // results held back while items keep coming
        run_random_phase(100);

        wait_idle();
        write_reg(ADDR_PERIOD, 32'd2);
        run_random_phase(100);

        wait_idle();
        write_reg(ADDR_PERIOD, 32'($urandom_range(4, 9)));
        run_random_phase(100);

        wait_idle();
        write_reg(ADDR_PERIOD, 32'd0);
        run_random_phase(100);

        // last part: no idling, longest period (upper bits beyond the field set too)
        wait_idle();
        idle_en = 1'b0;
        write_reg(ADDR_PERIOD, 32'hFFFF_FFFF);
        run_random_phase(100);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
design/trhm_pkg.sv
design/trhm_hist_mem.sv
design/trhm_peak_unit.sv
design/trhm_seq.sv
design/traffic_rate_history_monitor_unit.sv
dv/traffic_rate_history_monitor_checker.sv
dv/traffic_rate_history_monitor_unit_test.sv
